// ----- src/skd_pkg.sv -----
// Shared types, constants and helper functions for the SimCC keypoint decoder.
// No dependencies; used by simcc_keypoint_decode.
package skd_pkg;

	// Storage limits.
	localparam int MAX_BINS   = 1024;
	localparam int MAX_POINTS = 256;
	localparam int BIN_W      = $clog2(MAX_BINS);
	localparam int POINT_W    = 8;

	// Field widths fixed by the interface.
	localparam int SCORE_W  = 16;
	localparam int COORD_W  = 32;
	localparam int SCALE_W  = 24;
	localparam int COUNT_W  = 11;
	localparam int KPCNT_W  = 9;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// Coordinate arithmetic widths.
	localparam int PROD_W = BIN_W + SCALE_W;
	localparam int SUM_W  = ((PROD_W > COORD_W) ? PROD_W : COORD_W) + 2;

	// Coordinate reported for a rejected keypoint: -1.0 in Q16.16.
	localparam logic [COORD_W-1:0] REJECT_COORD = 32'hFFFF_0000;

	// Reset values of the configuration registers.
	localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd65536;
	localparam logic [COUNT_W-1:0] X_BINS_RESET  = 11'd384;
	localparam logic [COUNT_W-1:0] Y_BINS_RESET  = 11'd512;
	localparam logic [KPCNT_W-1:0] KPCNT_RESET   = 9'd133;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_SCALE_X   = 3'd2,
		REG_SCALE_Y   = 3'd3,
		REG_THRESHOLD = 3'd4,
		REG_X_BINS    = 3'd5,
		REG_Y_BINS    = 3'd6,
		REG_KP_COUNT  = 3'd7
	} cfg_reg_t;

	// Finished keypoint leaving the argmax stage.
	typedef struct packed {
		logic signed [SCORE_W-1:0] x_score;
		logic signed [SCORE_W-1:0] y_score;
		logic [BIN_W-1:0]          x_bin;
		logic [BIN_W-1:0]          y_bin;
		logic [POINT_W-1:0]        index;
		logic                      last;
	} argmax_t;

	// Highest bin index of an axis, with the count clamped to 1..MAX_BINS.
	function automatic logic [BIN_W-1:0] last_bin(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] m;
		begin
			if (n == '0) begin
				m = '0;
			end else if (n > COUNT_W'(MAX_BINS)) begin
				m = COUNT_W'(MAX_BINS - 1);
			end else begin
				m = n - COUNT_W'(1);
			end
			return m[BIN_W-1:0];
		end
	endfunction

	// Highest keypoint index of a frame, with the count clamped to 1..MAX_POINTS.
	function automatic logic [POINT_W-1:0] last_index(input logic [KPCNT_W-1:0] n);
		logic [KPCNT_W-1:0] m;
		begin
			if (n == '0) begin
				m = '0;
			end else if (n > KPCNT_W'(MAX_POINTS)) begin
				m = KPCNT_W'(MAX_POINTS - 1);
			end else begin
				m = n - KPCNT_W'(1);
			end
			return m[POINT_W-1:0];
		end
	endfunction

	// origin + product, computed exactly and saturated to the signed coordinate range.
	function automatic logic [COORD_W-1:0] sat_coord(
		input logic signed [COORD_W-1:0] origin,
		input logic [PROD_W-1:0]         prod
	);
		logic signed [SUM_W-1:0] s;
		logic [SUM_W-COORD_W:0]  top;
		begin
			s   = SUM_W'(origin) + signed'(SUM_W'(prod));
			top = s[SUM_W-1:COORD_W-1];
			if ((&top) || (~|top)) begin
				return s[COORD_W-1:0];
			end else if (s[SUM_W-1]) begin
				return {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				return {1'b0, {(COORD_W-1){1'b1}}};
			end
		end
	endfunction

endpackage

// ----- src/simcc_keypoint_decode.sv -----
// Top level of the SimCC keypoint decoder: argmax over the score stream and coordinate output.
// Depends on skd_pkg for widths, register codes and the clamp and saturate functions.
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  -------------------------------------------------
//  in       input      in_valid / in_stall    bin_score
//  out      output     out_valid / out_stall  point_x, point_y, point_score, rejected,
//                                             point_index, last_point
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One score transaction is taken per clock while in_stall is low. After its last y-axis score
// is accepted, a keypoint passes through the input register, the argmax stage, the multiply
// stage and the add-and-saturate output register.
// Reset clears the argmax state, the keypoint counter and all valid flags, and loads the
// registers with their default values; no clearing pass follows.
// An output stall holds the result register; the stages behind it keep filling, and only
// a score that finishes a keypoint waits for a free slot, so scores that end no keypoint
// keep flowing while a result is waiting.
module simcc_keypoint_decode (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Score stream
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [skd_pkg::SCORE_W-1:0]    bin_score,
	// Keypoint results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [skd_pkg::COORD_W-1:0]    point_x,
	output logic signed [skd_pkg::COORD_W-1:0]    point_y,
	output logic signed [skd_pkg::SCORE_W-1:0]    point_score,
	output logic                                  rejected,
	output logic [skd_pkg::POINT_W-1:0]           point_index,
	output logic                                  last_point,
	// Configuration writes
	input  logic                                  cfg_we,
	input  logic [skd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [skd_pkg::CFG_W-1:0]             cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [skd_pkg::COORD_W-1:0] origin_x_q, origin_y_q;
	logic [skd_pkg::SCALE_W-1:0]        scale_x_q, scale_y_q;
	logic signed [skd_pkg::SCORE_W-1:0] threshold_q;
	logic [skd_pkg::COUNT_W-1:0]        x_bins_q, y_bins_q;
	logic [skd_pkg::KPCNT_W-1:0]        kp_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			scale_x_q   <= skd_pkg::SCALE_RESET;
			scale_y_q   <= skd_pkg::SCALE_RESET;
			threshold_q <= '0;
			x_bins_q    <= skd_pkg::X_BINS_RESET;
			y_bins_q    <= skd_pkg::Y_BINS_RESET;
			kp_count_q  <= skd_pkg::KPCNT_RESET;
		end else if (cfg_we) begin
			unique case (skd_pkg::cfg_reg_t'(cfg_index))
				skd_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_data[skd_pkg::COORD_W-1:0];
				skd_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_data[skd_pkg::COORD_W-1:0];
				skd_pkg::REG_SCALE_X:   scale_x_q   <= cfg_data[skd_pkg::SCALE_W-1:0];
				skd_pkg::REG_SCALE_Y:   scale_y_q   <= cfg_data[skd_pkg::SCALE_W-1:0];
				skd_pkg::REG_THRESHOLD: threshold_q <= cfg_data[skd_pkg::SCORE_W-1:0];
				skd_pkg::REG_X_BINS:    x_bins_q    <= cfg_data[skd_pkg::COUNT_W-1:0];
				skd_pkg::REG_Y_BINS:    y_bins_q    <= cfg_data[skd_pkg::COUNT_W-1:0];
				skd_pkg::REG_KP_COUNT:  kp_count_q  <= cfg_data[skd_pkg::KPCNT_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage moves when the stage ahead is empty or moving; see move_s1 for stage 1.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_out, ready_s3, ready_s2, ready_s1;
	logic move_s1, move_s2, move_s3;
	logic point_done;

	assign ready_out = !out_valid || !out_stall;
	assign move_s3   = valid_s3 && ready_out;
	assign ready_s3  = !valid_s3 || ready_out;
	assign move_s2   = valid_s2 && ready_s3;
	assign ready_s2  = !valid_s2 || ready_s3;
	// A score that does not finish a keypoint is absorbed without needing a slot ahead.
	assign move_s1   = valid_s1 && (!point_done || ready_s2);
	assign ready_s1  = !valid_s1 || move_s1;
	assign in_stall  = !ready_s1;

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic signed [skd_pkg::SCORE_W-1:0] score_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			score_s1 <= bin_score;
		end
	end

	// ------------------------------------------------------------------
	// Running argmax per axis. Ties keep the earlier bin, and bin zero always loads.
	// ------------------------------------------------------------------
	logic signed [skd_pkg::SCORE_W-1:0] best_x_score_q, best_y_score_q;
	logic [skd_pkg::BIN_W-1:0]          best_x_bin_q, best_y_bin_q;
	logic [skd_pkg::BIN_W-1:0]          bin_pos_q;
	logic                               on_y_q;
	logic [skd_pkg::POINT_W-1:0]        point_cnt_q;

	logic signed [skd_pkg::SCORE_W-1:0] axis_best;
	logic [skd_pkg::BIN_W-1:0]          axis_last;
	logic                               take_bin;
	logic                               axis_end;
	logic                               frame_end;
	skd_pkg::argmax_t                   point_next;

	always_comb begin
		axis_best  = on_y_q ? best_y_score_q : best_x_score_q;
		axis_last  = skd_pkg::last_bin(on_y_q ? y_bins_q : x_bins_q);
		take_bin   = (bin_pos_q == '0) || (score_s1 > axis_best);
		// An axis ends once the position reaches its last bin, also after a smaller count
		// has been written while the position was beyond it.
		axis_end   = bin_pos_q >= axis_last;
		point_done = on_y_q && axis_end;
		frame_end  = point_cnt_q >= skd_pkg::last_index(kp_count_q);

		point_next.x_score = best_x_score_q;
		point_next.x_bin   = best_x_bin_q;
		point_next.y_score = take_bin ? score_s1 : best_y_score_q;
		point_next.y_bin   = take_bin ? bin_pos_q : best_y_bin_q;
		point_next.index   = point_cnt_q;
		point_next.last    = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_x_score_q <= '0;
			best_y_score_q <= '0;
			best_x_bin_q   <= '0;
			best_y_bin_q   <= '0;
			bin_pos_q      <= '0;
			on_y_q         <= 1'b0;
			point_cnt_q    <= '0;
		end else if (move_s1) begin
			if (take_bin) begin
				if (on_y_q) begin
					best_y_score_q <= score_s1;
					best_y_bin_q   <= bin_pos_q;
				end else begin
					best_x_score_q <= score_s1;
					best_x_bin_q   <= bin_pos_q;
				end
			end
			if (axis_end) begin
				bin_pos_q <= '0;
				on_y_q    <= !on_y_q;
				if (on_y_q) begin
					point_cnt_q <= frame_end ? '0 : point_cnt_q + skd_pkg::POINT_W'(1);
				end
			end else begin
				bin_pos_q <= bin_pos_q + skd_pkg::BIN_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: finished keypoint, axis maxima and their bins
	// ------------------------------------------------------------------
	skd_pkg::argmax_t point_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1 && point_done) begin
			valid_s2 <= 1'b1;
		end else if (move_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && point_done) begin
			point_s2 <= point_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: bin times scale, score mean and threshold test
	// ------------------------------------------------------------------
	logic [skd_pkg::SCORE_W:0]          score_sum;
	logic signed [skd_pkg::SCORE_W-1:0] score_mean;

	logic [skd_pkg::PROD_W-1:0]         prod_x_s3, prod_y_s3;
	logic signed [skd_pkg::SCORE_W-1:0] score_s3;
	logic                               reject_s3;
	logic [skd_pkg::POINT_W-1:0]        index_s3;
	logic                               last_s3;

	always_comb begin
		// Floor mean: the sum is one bit wider, and dropping its low bit is the
		// arithmetic shift.
		score_sum  = (skd_pkg::SCORE_W + 1)'(point_s2.x_score)
			+ (skd_pkg::SCORE_W + 1)'(point_s2.y_score);
		score_mean = score_sum[skd_pkg::SCORE_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			prod_x_s3 <= skd_pkg::PROD_W'(point_s2.x_bin) * skd_pkg::PROD_W'(scale_x_q);
			prod_y_s3 <= skd_pkg::PROD_W'(point_s2.y_bin) * skd_pkg::PROD_W'(scale_y_q);
			score_s3  <= score_mean;
			// Equal to the threshold keeps the coordinates.
			reject_s3 <= score_mean < threshold_q;
			index_s3  <= point_s2.index;
			last_s3   <= point_s2.last;
		end
	end

	// ------------------------------------------------------------------
	// Output register: origin plus product, saturated, or -1.0 when rejected
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_out) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) begin
			point_x     <= reject_s3 ? skd_pkg::REJECT_COORD
				: skd_pkg::sat_coord(origin_x_q, prod_x_s3);
			point_y     <= reject_s3 ? skd_pkg::REJECT_COORD
				: skd_pkg::sat_coord(origin_y_q, prod_y_s3);
			point_score <= score_s3;
			rejected    <= reject_s3;
			point_index <= index_s3;
			last_point  <= last_s3;
		end
	end

endmodule

// ----- verif/tb_simcc_keypoint_decode.sv -----
`timescale 1ns / 100ps
// Self-checking bench for simcc_keypoint_decode: directed and random score streams, with every
// keypoint predicted and compared field by field. Depends on skd_pkg and the decoder RTL.
module tb_simcc_keypoint_decode;

	localparam int HALF_PERIOD = 6;
	// Extra idle time after the last keypoint, so that scores that close no keypoint can drain.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int REPORT_LIMIT = 10;
	// Time limit for a full run, in nanoseconds.
	localparam longint TIMEOUT_NS = 64'd2_500_000;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	// One keypoint as it leaves the block, in port order.
	typedef struct packed {
		logic signed [skd_pkg::COORD_W-1:0] x;
		logic signed [skd_pkg::COORD_W-1:0] y;
		logic signed [skd_pkg::SCORE_W-1:0] score;
		logic                               rej;
		logic [skd_pkg::POINT_W-1:0]        index;
		logic                               last;
	} keypoint_t;

	// The scoreboard keeps its own copy of the registers and of the argmax state. Each
	// accepted score advances that state, and a score that closes the y axis queues the
	// keypoint it produces. Keypoints leaving the block are checked against the queue head.
	class keypoint_scoreboard;
		logic signed [skd_pkg::COORD_W-1:0] org_x, org_y;
		logic [skd_pkg::SCALE_W-1:0]        step_x, step_y;
		logic signed [skd_pkg::SCORE_W-1:0] floor_score;
		logic [skd_pkg::COUNT_W-1:0]        span_x, span_y;
		logic [skd_pkg::KPCNT_W-1:0]        frame_len;
		logic signed [skd_pkg::SCORE_W-1:0] peak_x, peak_y;
		logic [skd_pkg::BIN_W-1:0]          peak_x_bin, peak_y_bin, bin_pos;
		logic                               on_y;
		logic [skd_pkg::POINT_W-1:0]        point_no;
		keypoint_t                          pending_keypoints[$];
		int                                 mismatches, checked, rejects, frames;

		function new();
			org_x = '0;
			org_y = '0;
			step_x = 24'd65536;
			step_y = 24'd65536;
			floor_score = '0;
			span_x = 11'd384;
			span_y = 11'd512;
			frame_len = 9'd133;
			peak_x = '0;
			peak_y = '0;
			peak_x_bin = '0;
			peak_y_bin = '0;
			bin_pos = '0;
			on_y = 1'b0;
			point_no = '0;
			mismatches = 0;
			checked = 0;
			rejects = 0;
			frames = 0;
		endfunction

		function void write_reg(skd_pkg::cfg_reg_t idx, logic [skd_pkg::CFG_W-1:0] d);
			case (idx)
				skd_pkg::REG_ORIGIN_X:  org_x = d;
				skd_pkg::REG_ORIGIN_Y:  org_y = d;
				skd_pkg::REG_SCALE_X:   step_x = d[skd_pkg::SCALE_W-1:0];
				skd_pkg::REG_SCALE_Y:   step_y = d[skd_pkg::SCALE_W-1:0];
				skd_pkg::REG_THRESHOLD: floor_score = d[skd_pkg::SCORE_W-1:0];
				skd_pkg::REG_X_BINS:    span_x = d[skd_pkg::COUNT_W-1:0];
				skd_pkg::REG_Y_BINS:    span_y = d[skd_pkg::COUNT_W-1:0];
				skd_pkg::REG_KP_COUNT:  frame_len = d[skd_pkg::KPCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned effective(int unsigned v, int unsigned hi);
			if (v == 0) return 1;
			return (v > hi) ? hi : v;
		endfunction

		function logic signed [skd_pkg::COORD_W-1:0] place(
				logic signed [skd_pkg::COORD_W-1:0] origin,
				logic [skd_pkg::BIN_W-1:0] b, logic [skd_pkg::SCALE_W-1:0] s);
			longint sum;
			sum = longint'(origin) + longint'(b) * longint'(s);
			if (sum > COORD_MAX) sum = COORD_MAX;
			if (sum < COORD_MIN) sum = COORD_MIN;
			return sum[skd_pkg::COORD_W-1:0];
		endfunction

		function void take_score(logic signed [skd_pkg::SCORE_W-1:0] s);
			int unsigned nb, limit;
			logic signed [skd_pkg::SCORE_W:0] sum;
			keypoint_t kp;
			if (!on_y) begin
				if (bin_pos == 0 || s > peak_x) begin
					peak_x = s;
					peak_x_bin = bin_pos;
				end
				nb = effective(span_x, skd_pkg::MAX_BINS);
				if (bin_pos >= nb - 1) begin
					bin_pos = '0;
					on_y = 1'b1;
				end else begin
					bin_pos = bin_pos + 1'b1;
				end
				return;
			end
			if (bin_pos == 0 || s > peak_y) begin
				peak_y = s;
				peak_y_bin = bin_pos;
			end
			nb = effective(span_y, skd_pkg::MAX_BINS);
			if (bin_pos < nb - 1) begin
				bin_pos = bin_pos + 1'b1;
				return;
			end
			bin_pos = '0;
			on_y = 1'b0;
			sum = peak_x + peak_y;
			kp.score = skd_pkg::SCORE_W'(sum >>> 1);
			kp.rej = kp.score < floor_score;
			kp.x = kp.rej ? skd_pkg::REJECT_COORD : place(org_x, peak_x_bin, step_x);
			kp.y = kp.rej ? skd_pkg::REJECT_COORD : place(org_y, peak_y_bin, step_y);
			limit = effective(frame_len, skd_pkg::MAX_POINTS);
			kp.index = point_no;
			kp.last = point_no >= limit - 1;
			point_no = kp.last ? '0 : point_no + 1'b1;
			pending_keypoints = {pending_keypoints, kp};
		endfunction

		function void check_point(keypoint_t got);
			keypoint_t want;
			checked++;
			if (pending_keypoints.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: keypoint x=%0d y=%0d score=%0d arrived with none due",
						$time, got.x, got.y, got.score);
				return;
			end
			want = pending_keypoints.pop_front();
			if (want.rej) rejects++;
			if (want.last) frames++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: keypoint mismatch", $time);
					$display("  expected x=%0d y=%0d score=%0d rejected=%0b index=%0d last=%0b",
						want.x, want.y, want.score, want.rej, want.index, want.last);
					$display("  actual   x=%0d y=%0d score=%0d rejected=%0b index=%0d last=%0b",
						got.x, got.y, got.score, got.rej, got.index, got.last);
				end
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [skd_pkg::SCORE_W-1:0] bin_score;
	logic                               out_valid;
	logic                               out_stall;
	logic signed [skd_pkg::COORD_W-1:0] point_x;
	logic signed [skd_pkg::COORD_W-1:0] point_y;
	logic signed [skd_pkg::SCORE_W-1:0] point_score;
	logic                               rejected;
	logic [skd_pkg::POINT_W-1:0]        point_index;
	logic                               last_point;
	logic                               cfg_we;
	logic [skd_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [skd_pkg::CFG_W-1:0]          cfg_data;

	keypoint_scoreboard board = new();

	// Register values for the next configuration pass, indexed by register code.
	logic [skd_pkg::CFG_W-1:0] reg_plan [8];
	int in_gap_pct;
	int out_stall_pct;
	int items_sent;
	int settings_loaded;

	simcc_keypoint_decode uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bin_score(bin_score),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.point_score(point_score),
		.rejected(rejected),
		.point_index(point_index),
		.last_point(last_point),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// The receiver decides its stall for the coming edge at each falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_stall_pct);
	end

	// A result transaction completes at a rising edge with out_valid high and out_stall low.
	// The outputs are read before the edge updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_point({point_x, point_y, point_score, rejected, point_index, last_point});
	end

	// Offers one score and holds it until the block takes it. Idle cycles are inserted only
	// before valid rises, so valid never reacts to stall and a waiting score stays put.
	// The task starts and ends at a falling edge.
	task automatic send_score(input logic signed [skd_pkg::SCORE_W-1:0] v);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		bin_score <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.take_score(v);
		items_sent++;
		@(negedge clk);
	endtask

	// Stops offering scores until every predicted keypoint has been seen. At least one
	// falling edge passes, so the next driver starts in a fresh time step.
	task automatic await_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.pending_keypoints.size() != 0) @(negedge clk);
	endtask

	// Brings the block to rest. Scores that close no keypoint may still sit in the pipeline
	// when the last keypoint has left, so extra idle cycles pass before anything else.
	task automatic settle();
		await_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes every register from the plan, one per cycle, then drops the write enable.
	task automatic load_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= skd_pkg::CFG_IDX_W'(i);
			cfg_data <= reg_plan[i];
			@(posedge clk);
			board.write_reg(skd_pkg::cfg_reg_t'(i), reg_plan[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
			1: begin in_gap_pct = 84; out_stall_pct = 0;  end
			2: begin in_gap_pct = 0;  out_stall_pct = 84; end
			default: begin in_gap_pct = 10; out_stall_pct = 10; end
		endcase
	endtask

	// Scores lean toward the extremes and toward a narrow band around zero, where ties
	// between bins are common.
	function automatic logic signed [skd_pkg::SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return skd_pkg::SCORE_W'($urandom_range(0, 8)) - 16'd4;
			default: return skd_pkg::SCORE_W'($urandom);
		endcase
	endfunction

	function automatic logic [skd_pkg::CFG_W-1:0] pick_origin();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return 32'h7FF0_0000 + $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [skd_pkg::CFG_W-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'h00FF_FFFF;
			2: return 32'h0001_0000;
			default: return $urandom & 32'h00FF_FFFF;
		endcase
	endfunction

	function automatic logic [skd_pkg::CFG_W-1:0] pick_threshold();
		case ($urandom_range(0, 4))
			0: return 32'h0000_8000;
			1: return 32'h0000_7FFF;
			2: return '0;
			default: return $urandom & 32'h0000_FFFF;
		endcase
	endfunction

	// Bin counts stay small so keypoints come often; zero and mid sizes show up now and then.
	function automatic logic [skd_pkg::CFG_W-1:0] pick_bins();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom_range(9, 40);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic logic [skd_pkg::CFG_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom_range(257, 511);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic void shuffle_regs();
		reg_plan[skd_pkg::REG_ORIGIN_X] = pick_origin();
		reg_plan[skd_pkg::REG_ORIGIN_Y] = pick_origin();
		reg_plan[skd_pkg::REG_SCALE_X] = pick_scale();
		reg_plan[skd_pkg::REG_SCALE_Y] = pick_scale();
		reg_plan[skd_pkg::REG_THRESHOLD] = pick_threshold();
		reg_plan[skd_pkg::REG_X_BINS] = pick_bins();
		reg_plan[skd_pkg::REG_Y_BINS] = pick_bins();
		reg_plan[skd_pkg::REG_KP_COUNT] = pick_count();
	endfunction

	initial begin
		int budget;
		int failures;
		arst_n = 1'b0;
		in_valid = 1'b0;
		bin_score = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_gap_pct = 0;
		out_stall_pct = 0;
		items_sent = 0;
		settings_loaded = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Two bins per axis, two keypoints per frame and a threshold of -1. The first keypoint
		// has its maxima at opposite ends of the axes, the second ties on the most negative
		// score everywhere and is rejected, and the third lands exactly on the threshold
		// through a floor mean of a negative odd sum. Its index shows the frame wrap.
		reg_plan[skd_pkg::REG_ORIGIN_X] = 32'h0001_0000;
		reg_plan[skd_pkg::REG_ORIGIN_Y] = 32'h0000_8000;
		reg_plan[skd_pkg::REG_SCALE_X] = 32'h0002_8000;
		reg_plan[skd_pkg::REG_SCALE_Y] = 32'h0001_0000;
		reg_plan[skd_pkg::REG_THRESHOLD] = 32'h0000_FFFF;
		reg_plan[skd_pkg::REG_X_BINS] = 32'd2;
		reg_plan[skd_pkg::REG_Y_BINS] = 32'd2;
		reg_plan[skd_pkg::REG_KP_COUNT] = 32'd2;
		load_regs();
		send_score(16'sh7FFF);
		send_score(16'sh8000);
		send_score(16'sh8000);
		send_score(16'sh7FFF);
		repeat (4) send_score(16'sh8000);
		send_score(16'sh0000);
		send_score(16'sh0000);
		send_score(16'shFFFF);
		send_score(16'shFFFE);
		settle();

		// Zero bin and keypoint counts act as one, so each pair of scores is a whole frame.
		// The origins sit at both ends of the coordinate range, and the lowest threshold
		// keeps every keypoint.
		reg_plan[skd_pkg::REG_ORIGIN_X] = 32'h7FFF_FFFF;
		reg_plan[skd_pkg::REG_ORIGIN_Y] = 32'h8000_0000;
		reg_plan[skd_pkg::REG_SCALE_X] = 32'h00FF_FFFF;
		reg_plan[skd_pkg::REG_SCALE_Y] = 32'h00FF_FFFF;
		reg_plan[skd_pkg::REG_THRESHOLD] = 32'h0000_8000;
		reg_plan[skd_pkg::REG_X_BINS] = '0;
		reg_plan[skd_pkg::REG_Y_BINS] = '0;
		reg_plan[skd_pkg::REG_KP_COUNT] = '0;
		load_regs();
		send_score(16'sh1234);
		send_score(16'shEDCB);
		settle();

		// A large origin plus bin two times the largest scale must saturate. After one full
		// keypoint a second one is left half done, on the y axis at bin two.
		reg_plan[skd_pkg::REG_ORIGIN_X] = 32'h7FFF_0000;
		reg_plan[skd_pkg::REG_ORIGIN_Y] = 32'hFFFF_0000;
		reg_plan[skd_pkg::REG_SCALE_Y] = 32'h0001_0000;
		reg_plan[skd_pkg::REG_X_BINS] = 32'd3;
		reg_plan[skd_pkg::REG_Y_BINS] = 32'd3;
		reg_plan[skd_pkg::REG_KP_COUNT] = 32'd3;
		load_regs();
		send_score(16'sd1);
		send_score(16'sd2);
		send_score(16'sd3);
		send_score(16'sd5);
		send_score(16'sd5);
		send_score(16'sd4);
		repeat (3) send_score(16'sh8000);
		send_score(16'sd10);
		send_score(16'sd20);
		settle();

		// Shrinking the y bin count and the keypoint count below the current position means
		// the next score closes the axis, and the keypoint closes the frame at once.
		reg_plan[skd_pkg::REG_Y_BINS] = 32'd1;
		reg_plan[skd_pkg::REG_KP_COUNT] = 32'd1;
		load_regs();
		send_score(16'sd0);
		settle();

		// A keypoint count beyond the limit acts as the limit: run one keypoint past the wrap
		// with one bin per axis while the receiver stalls hard.
		set_idle(2);
		shuffle_regs();
		reg_plan[skd_pkg::REG_X_BINS] = 32'd1;
		reg_plan[skd_pkg::REG_Y_BINS] = '0;
		reg_plan[skd_pkg::REG_KP_COUNT] = 32'd511;
		load_regs();
		repeat (2 * (skd_pkg::MAX_POINTS + 1)) send_score(pick_score());
		settle();

		// Random register settings, each held for about a hundred scores. Phases end wherever
		// the item count runs out, so the next setting often lands in the middle of a keypoint.
		// Halfway through each phase the sender holds off until the block has caught up.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_idle(phase);
			shuffle_regs();
			load_regs();
			budget = PHASE_ITEMS + $urandom_range(0, 30);
			for (int i = 0; i < budget; i++) begin
				if (i == budget / 2) await_results();
				send_score(pick_score());
			end
			settle();
		end

		failures = board.mismatches + board.pending_keypoints.size();
		$display("Sent %0d score transactions under %0d register settings and four idle patterns.",
			items_sent, settings_loaded);
		$display("Checked %0d keypoints: %0d rejected, %0d frames closed, %0d mismatches.",
			board.checked, board.rejects, board.frames, board.mismatches);
		if (failures == 0) begin
			$display("simcc_keypoint_decode regression: pass");
		end else begin
			$display("simcc_keypoint_decode regression: fail");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("simcc_keypoint_decode regression: fail");
		$finish;
	end

endmodule
